/* rtl/core/looping_ads_envelope_gain_unit_macros.svh */
// Assertion macros shared by the envelope gain unit and its serial units.
// Needs nothing else; take it in with an include after the net type line.
`ifndef LOOPING_ADS_ENVELOPE_GAIN_UNIT_MACROS_SVH
`define LOOPING_ADS_ENVELOPE_GAIN_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define LADS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define LADS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lads_pkg.sv */
// Shared widths, register indexes, phase codes and the configuration record
// of the looping envelope gain unit. Depends on nothing.
`default_nettype none

package lads_pkg;

    localparam int LEN_W          = 20;
    localparam int GAIN_W         = 16;
    localparam int SAMPLE_W       = 16;
    localparam int PHASE_W        = 2;
    localparam int FRAC_BITS      = 15;
    localparam int AD_W           = LEN_W + 1;
    localparam int END_W          = LEN_W + 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 20;
    localparam int FRAME_BITS_DEF = 22;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUS_GAIN = 3'd4;

    localparam logic [PHASE_W-1:0] PHASE_ATTACK  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_DECAY   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_SUSTAIN = 2'd2;

    // Q1.15 unity, also the attack ramp scale
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

    localparam logic [LEN_W-1:0]  RST_ATTACK   = 20'd14400;
    localparam logic [LEN_W-1:0]  RST_DECAY    = 20'd14400;
    localparam logic [LEN_W-1:0]  RST_SUSTAIN  = 20'd48000;
    localparam logic [GAIN_W-1:0] RST_PEAK     = 16'd32768;
    localparam logic [GAIN_W-1:0] RST_SUS_GAIN = 16'd16384;

    typedef struct packed {
        logic [LEN_W-1:0]  attack_frames;
        logic [LEN_W-1:0]  decay_frames;
        logic [LEN_W-1:0]  sustain_frames;
        logic [GAIN_W-1:0] peak_gain;
        logic [GAIN_W-1:0] sustain_gain;
    } lads_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/looping_ads_envelope_gain_unit.sv */
// Looping attack/decay/sustain envelope gain: top level, sequencer, frame
// counter and output register. Depends on lads_pkg, lads_cfg_regs,
// lads_mul_serial, lads_div_serial and the macro header.
//
//   port group   direction  moves
//   s_*          in         sample_in, restart
//   m_*          out        sample_out, phase, gain_applied
//   cfg_*        in         register index and write data
//
// Attack and decay requests raise m_valid after two 16-step multiplier passes and a
// 16-step divide; sustain and wrap requests after a single multiplier pass. s_ready
// rises in the same cycle as m_valid; no request is taken before the last is loaded.
// Reset is synchronous, active low; it restores the register defaults and
// clears the frame counter. A result waiting on m_ready does not block the
// next accept; only the final load stalls until the output register frees.
`default_nettype none
`include "looping_ads_envelope_gain_unit_macros.svh"

module looping_ads_envelope_gain_unit #(
    parameter int FRAME_BITS = lads_pkg::FRAME_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [lads_pkg::SAMPLE_W-1:0] s_sample_in,
    input  wire logic                              s_restart,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [lads_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic [lads_pkg::PHASE_W-1:0]           m_phase,
    output logic [lads_pkg::GAIN_W-1:0]            m_gain_applied,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lads_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lads_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LEN_W    = lads_pkg::LEN_W;
    localparam int GAIN_W   = lads_pkg::GAIN_W;
    localparam int SAMPLE_W = lads_pkg::SAMPLE_W;
    localparam int PHASE_W  = lads_pkg::PHASE_W;
    localparam int AD_W     = lads_pkg::AD_W;
    localparam int END_W    = lads_pkg::END_W;
    localparam int CMP_W    = (FRAME_BITS > END_W) ? FRAME_BITS : END_W;
    localparam int P_W      = LEN_W + GAIN_W;
    localparam int OUT_P_W  = SAMPLE_W + GAIN_W;
    localparam int Y_W      = OUT_P_W + 1 - lads_pkg::FRAC_BITS;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SUM      = 7'b0000010,
        ST_CMP      = 7'b0000100,
        ST_MUL_GAIN = 7'b0001000,
        ST_DIV      = 7'b0010000,
        ST_MUL_OUT  = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    lads_pkg::lads_cfg_t cfg;

    state_t                      state_reg,     state_next;
    logic [FRAME_BITS-1:0]       frame_cnt_reg, frame_cnt_next;
    logic                        go_reg,        go_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0]  sample_reg,    sample_next;
    logic [AD_W-1:0]             ad_reg,        ad_next;
    logic [END_W-1:0]            end_reg,       end_next;
    logic [PHASE_W-1:0]          phase_reg,     phase_next;
    logic                        dec_neg_reg,   dec_neg_next;
    logic [GAIN_W-1:0]           gain_reg,      gain_next;
    logic [LEN_W-1:0]            op_a_reg,      op_a_next;
    logic [GAIN_W-1:0]           op_b_reg,      op_b_next;
    logic [LEN_W-1:0]            den_reg,       den_next;
    logic signed [SAMPLE_W-1:0]  out_sample_reg, out_sample_next;
    logic [PHASE_W-1:0]          out_phase_reg,  out_phase_next;
    logic [GAIN_W-1:0]           out_gain_reg,   out_gain_next;

    logic                mul_done;
    logic [P_W-1:0]      mul_product;
    logic                div_start;
    logic                div_done;
    logic [GAIN_W-1:0]   div_quotient;

    logic [CMP_W-1:0]    f_cmp;
    logic [CMP_W-1:0]    a_cmp;
    logic [CMP_W-1:0]    ad_cmp;
    logic [CMP_W-1:0]    end_cmp;
    logic [CMP_W-1:0]    fa_diff;
    logic [GAIN_W:0]     delta;
    logic [GAIN_W:0]     delta_neg;
    logic [GAIN_W-1:0]   delta_mag;
    logic [SAMPLE_W-1:0] sample_abs;
    logic [GAIN_W:0]     gain_up;
    logic [GAIN_W:0]     gain_dn;
    logic [GAIN_W-1:0]   gain_calc;
    logic [OUT_P_W:0]    p_ext;
    logic [OUT_P_W:0]    p_signed;
    logic [Y_W-1:0]      y_full;
    logic [Y_W-SAMPLE_W:0] y_top;
    logic [SAMPLE_W-1:0] y_sat;
    logic                out_free;

    lads_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lads_mul_serial #(
        .A_W (LEN_W),
        .B_W (GAIN_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg),
        .mcand   (op_a_reg),
        .mplier  (op_b_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    lads_div_serial #(
        .D_W (LEN_W),
        .Q_W (GAIN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // phase boundaries, compared at a common width
    assign f_cmp   = CMP_W'(frame_cnt_reg);
    assign a_cmp   = CMP_W'(cfg.attack_frames);
    assign ad_cmp  = CMP_W'(ad_reg);
    assign end_cmp = CMP_W'(end_reg);
    assign fa_diff = f_cmp - a_cmp;

    assign delta      = {1'b0, cfg.peak_gain} - {1'b0, cfg.sustain_gain};
    assign delta_neg  = ~delta + (GAIN_W+1)'(1);
    assign delta_mag  = delta[GAIN_W] ? delta_neg[GAIN_W-1:0] : delta[GAIN_W-1:0];
    assign sample_abs = sample_reg[SAMPLE_W-1] ? (~sample_reg + SAMPLE_W'(1)) : sample_reg;

    // decay moves from peak toward sustain by the truncated quotient
    assign gain_up   = {1'b0, cfg.peak_gain} + {1'b0, div_quotient};
    assign gain_dn   = {1'b0, cfg.peak_gain} - {1'b0, div_quotient};
    assign gain_calc = (phase_reg == lads_pkg::PHASE_ATTACK) ? div_quotient
                     : (dec_neg_reg ? gain_up[GAIN_W-1:0] : gain_dn[GAIN_W-1:0]);

    // restore the sign, floor-shift by the fraction bits, then saturate
    assign p_ext    = {1'b0, mul_product[OUT_P_W-1:0]};
    assign p_signed = sample_reg[SAMPLE_W-1] ? (~p_ext + (OUT_P_W+1)'(1)) : p_ext;
    assign y_full   = p_signed[OUT_P_W:lads_pkg::FRAC_BITS];
    assign y_top    = y_full[Y_W-1:SAMPLE_W-1];
    assign y_sat    = ((&y_top) || !(|y_top)) ? y_full[SAMPLE_W-1:0]
                    : (y_full[Y_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_W-1){1'b1}}});

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        frame_cnt_next  = frame_cnt_reg;
        go_next         = 1'b0;
        out_valid_next  = out_valid_reg;
        sample_next     = sample_reg;
        ad_next         = ad_reg;
        end_next        = end_reg;
        phase_next      = phase_reg;
        dec_neg_next    = dec_neg_reg;
        gain_next       = gain_reg;
        op_a_next       = op_a_reg;
        op_b_next       = op_b_reg;
        den_next        = den_reg;
        out_sample_next = out_sample_reg;
        out_phase_next  = out_phase_reg;
        out_gain_next   = out_gain_reg;
        div_start       = 1'b0;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample_in;
                    if (s_restart) begin
                        frame_cnt_next = '0;
                    end
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                ad_next    = AD_W'(cfg.attack_frames) + AD_W'(cfg.decay_frames);
                end_next   = END_W'(ad_next) + END_W'(cfg.sustain_frames);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                go_next        = 1'b1;
                frame_cnt_next = frame_cnt_reg + FRAME_BITS'(1);
                if (f_cmp < a_cmp) begin
                    phase_next = lads_pkg::PHASE_ATTACK;
                    op_a_next  = f_cmp[LEN_W-1:0];
                    op_b_next  = lads_pkg::GAIN_UNITY;
                    den_next   = cfg.attack_frames;
                    state_next = ST_MUL_GAIN;
                end else if (f_cmp < ad_cmp) begin
                    phase_next   = lads_pkg::PHASE_DECAY;
                    dec_neg_next = delta[GAIN_W];
                    op_a_next    = fa_diff[LEN_W-1:0];
                    op_b_next    = delta_mag;
                    den_next     = cfg.decay_frames;
                    state_next   = ST_MUL_GAIN;
                end else if (f_cmp < end_cmp) begin
                    phase_next = lads_pkg::PHASE_SUSTAIN;
                    gain_next  = cfg.sustain_gain;
                    op_a_next  = LEN_W'(sample_abs);
                    op_b_next  = cfg.sustain_gain;
                    state_next = ST_MUL_OUT;
                end else begin
                    // past the loop end: wrap to frame zero, silent attack
                    phase_next     = lads_pkg::PHASE_ATTACK;
                    gain_next      = '0;
                    op_a_next      = LEN_W'(sample_abs);
                    op_b_next      = '0;
                    frame_cnt_next = FRAME_BITS'(1);
                    state_next     = ST_MUL_OUT;
                end
            end
            ST_MUL_GAIN: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    gain_next  = gain_calc;
                    op_a_next  = LEN_W'(sample_abs);
                    op_b_next  = gain_calc;
                    go_next    = 1'b1;
                    state_next = ST_MUL_OUT;
                end
            end
            ST_MUL_OUT: begin
                if (mul_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register frees
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = y_sat;
                    out_phase_next  = phase_reg;
                    out_gain_next   = gain_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            frame_cnt_reg <= '0;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            frame_cnt_reg <= frame_cnt_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        ad_reg         <= ad_next;
        end_reg        <= end_next;
        phase_reg      <= phase_next;
        dec_neg_reg    <= dec_neg_next;
        gain_reg       <= gain_next;
        op_a_reg       <= op_a_next;
        op_b_reg       <= op_b_next;
        den_reg        <= den_next;
        out_sample_reg <= out_sample_next;
        out_phase_reg  <= out_phase_next;
        out_gain_reg   <= out_gain_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = out_valid_reg;
    assign m_sample_out   = out_sample_reg;
    assign m_phase        = out_phase_reg;
    assign m_gain_applied = out_gain_reg;

    `LADS_ASSERT_NEXT(a_restart_clears_count, aclk, aresetn, s_valid && s_ready && s_restart, frame_cnt_reg == '0, "restart did not clear the frame counter")
    `LADS_ASSERT_SAME(a_attack_gain_below_unity, aclk, aresetn, out_valid_reg && (out_phase_reg == lads_pkg::PHASE_ATTACK), !out_gain_reg[GAIN_W-1], "attack gain reached unity")

endmodule

`default_nettype wire

/* rtl/core/lads_cfg_regs.sv */
// Configuration register file of the envelope gain unit: decodes writes by
// index into the five settings. Depends on lads_pkg.
`default_nettype none

module lads_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           wr_en,
    input  wire logic [lads_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [lads_pkg::CFG_DATA_W-1:0] wr_data,
    output lads_pkg::lads_cfg_t                 cfg
);

    lads_pkg::lads_cfg_t cfg_reg;
    lads_pkg::lads_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                lads_pkg::REG_ATTACK:   cfg_next.attack_frames  = wr_data[lads_pkg::LEN_W-1:0];
                lads_pkg::REG_DECAY:    cfg_next.decay_frames   = wr_data[lads_pkg::LEN_W-1:0];
                lads_pkg::REG_SUSTAIN:  cfg_next.sustain_frames = wr_data[lads_pkg::LEN_W-1:0];
                lads_pkg::REG_PEAK:     cfg_next.peak_gain      = wr_data[lads_pkg::GAIN_W-1:0];
                lads_pkg::REG_SUS_GAIN: cfg_next.sustain_gain   = wr_data[lads_pkg::GAIN_W-1:0];
                // drop writes to unmapped indexes
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_frames  <= lads_pkg::RST_ATTACK;
            cfg_reg.decay_frames   <= lads_pkg::RST_DECAY;
            cfg_reg.sustain_frames <= lads_pkg::RST_SUSTAIN;
            cfg_reg.peak_gain      <= lads_pkg::RST_PEAK;
            cfg_reg.sustain_gain   <= lads_pkg::RST_SUS_GAIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/lads_mul_serial.sv */
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle, MSB first.
// The gain unit runs it once or twice per request. Depends on the macro header.
`default_nettype none
`include "looping_ads_envelope_gain_unit_macros.svh"

module lads_mul_serial #(
    parameter int A_W = 20,
    parameter int B_W = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     mcand,
    input  wire logic [B_W-1:0]     mplier,
    output logic                    done,
    output logic [A_W+B_W-1:0]      product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [P_W-1:0]   acc_reg,   acc_next;
    logic [A_W-1:0]   mcand_reg, mcand_next;
    logic [B_W-1:0]   mpl_reg,   mpl_next;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mpl_next   = mpl_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(B_W);
            acc_next   = '0;
            mcand_next = mcand;
            mpl_next   = mplier;
        end else if (busy_reg) begin
            acc_next = {acc_reg[P_W-2:0], 1'b0}
                     + (mpl_reg[B_W-1] ? P_W'(mcand_reg) : '0);
            mpl_next = {mpl_reg[B_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mpl_reg   <= mpl_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

    `LADS_ASSERT_SAME(a_mul_no_restart_busy, aclk, aresetn, start, !busy_reg, "multiplier restarted while busy")

endmodule

`default_nettype wire

/* rtl/core/lads_div_serial.sv */
// Restoring divider, one quotient bit per cycle. The caller keeps the upper
// dividend bits below the divisor. Depends on the macro header.
`default_nettype none
`include "looping_ads_envelope_gain_unit_macros.svh"

module lads_div_serial #(
    parameter int D_W = 20,
    parameter int Q_W = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [D_W+Q_W-1:0] dividend,
    input  wire logic [D_W-1:0]     divisor,
    output logic                    done,
    output logic [Q_W-1:0]          quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [D_W-1:0]   rem_reg,  rem_next;
    logic [Q_W-1:0]   quo_reg,  quo_next;
    logic [D_W-1:0]   div_reg,  div_next;

    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         fits;

    // dividend bits move out of the top of quo_reg as quotient bits enter below
    assign trial = {rem_reg, quo_reg[Q_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(Q_W);
            rem_next  = dividend[D_W+Q_W-1:Q_W];
            quo_next  = dividend[Q_W-1:0];
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `LADS_ASSERT_SAME(a_div_rem_bounded, aclk, aresetn, done_reg, rem_reg < div_reg, "divider remainder not below divisor")

endmodule

`default_nettype wire

/* sim/looping_ads_envelope_gain_unit_tb.sv */
// Self-checking bench for the looping attack/decay/sustain envelope gain unit.
// Holds its own envelope tracker and result queue; needs lads_pkg and the unit.
`timescale 1ns / 100ps

module looping_ads_envelope_gain_unit_tb;
    import lads_pkg::*;

    localparam int FRAME_BITS   = FRAME_BITS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 500;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [LEN_W-1:0]     LEN_MAX      = '1;
    localparam logic [GAIN_W-1:0]    GAIN_MAX     = '1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [PHASE_W-1:0]         phase;
        logic [GAIN_W-1:0]          gain_applied;
    } env_result_t;

    class envelope_tracker;
        lads_cfg_t             cfg;
        logic [FRAME_BITS-1:0] frame_cnt;
        env_result_t           due_q[$];
        int                    errors;

        function new();
            cfg.attack_frames  = RST_ATTACK;
            cfg.decay_frames   = RST_DECAY;
            cfg.sustain_frames = RST_SUSTAIN;
            cfg.peak_gain      = RST_PEAK;
            cfg.sustain_gain   = RST_SUS_GAIN;
            frame_cnt          = '0;
            errors             = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ATTACK:   cfg.attack_frames  = data[LEN_W-1:0];
                REG_DECAY:    cfg.decay_frames   = data[LEN_W-1:0];
                REG_SUSTAIN:  cfg.sustain_frames = data[LEN_W-1:0];
                REG_PEAK:     cfg.peak_gain      = data[GAIN_W-1:0];
                REG_SUS_GAIN: cfg.sustain_gain   = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] smp, logic rst);
            longint unsigned a, ad, fin, f;
            longint          g, num, y;
            env_result_t     r;
            a   = cfg.attack_frames;
            ad  = a + cfg.decay_frames;
            fin = ad + cfg.sustain_frames;
            if (rst)
                frame_cnt = '0;
            f = frame_cnt;
            if (f < a) begin
                r.phase = PHASE_ATTACK;
                g = longint'((f * GAIN_UNITY) / a);
            end else if (f < ad) begin
                // signed divide truncates toward zero, so a rising ramp stays on or
                // below the exact line
                num = longint'(f - a) *
                      (longint'(cfg.peak_gain) - longint'(cfg.sustain_gain));
                r.phase = PHASE_DECAY;
                g = longint'(cfg.peak_gain) - num / longint'(cfg.decay_frames);
            end else if (f < fin) begin
                r.phase = PHASE_SUSTAIN;
                g = longint'(cfg.sustain_gain);
            end else begin
                f = 0;
                r.phase = PHASE_ATTACK;
                g = 0;
            end
            frame_cnt = FRAME_BITS'(f + 1);
            y = (longint'(smp) * g) >>> FRAC_BITS;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            r.sample_out   = y[SAMPLE_W-1:0];
            r.gain_applied = g[GAIN_W-1:0];
            due_q.push_back(r);
        endfunction

        function void check_output(logic signed [SAMPLE_W-1:0] smp, logic [PHASE_W-1:0] ph,
                                   logic [GAIN_W-1:0] g);
            env_result_t want;
            if (due_q.size() == 0) begin
                $error("sample_out: no result expected, got %0d", smp);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (smp !== want.sample_out) begin
                $error("sample_out: expected %0d, got %0d", want.sample_out, smp);
                errors++;
            end
            if (ph !== want.phase) begin
                $error("phase: expected %0d, got %0d", want.phase, ph);
                errors++;
            end
            if (g !== want.gain_applied) begin
                $error("gain_applied: expected %0d, got %0d", want.gain_applied, g);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction
    endclass

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in    = '0;
    logic                       s_restart      = 1'b0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic [PHASE_W-1:0]         m_phase;
    logic [GAIN_W-1:0]          m_gain_applied;
    logic                       cfg_valid      = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [CFG_DATA_W-1:0]      cfg_data       = '0;

    bit              steady_flow = 1'b0;
    int              cycle_cnt   = 0;
    envelope_tracker tracker     = new();

    looping_ads_envelope_gain_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out),
        .m_phase        (m_phase),
        .m_gain_applied (m_gain_applied),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Check results before noting the new request taken at the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_output(m_sample_out, m_phase, m_gain_applied);
            if (s_valid && s_ready)
                tracker.take_sample(s_sample_in, s_restart);
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (!steady_flow && $urandom_range(0, 99) < 4) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("looping_ads_envelope_gain_unit_tb: done, errors");
        $finish;
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic rst);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 30)
            gap = $urandom_range(1, 30);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= smp;
        s_restart   <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop the request line and hold until every result is back
    task automatic end_batch();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] data;
        int                    pick;
        for (int k = REG_ATTACK; k <= REG_SUS_GAIN; k++) begin
            if ($urandom_range(0, 99) < 70) begin
                pick = $urandom_range(0, 9);
                data = CFG_DATA_W'($urandom);
                if (k <= REG_SUSTAIN) begin
                    case (pick)
                        0:       data = '0;
                        1:       data = LEN_MAX;
                        2:       data = CFG_DATA_W'($urandom_range(0, 3000));
                        default: data = CFG_DATA_W'($urandom_range(0, 24));
                    endcase
                end else begin
                    // upper data bits stay random; the register keeps the low 16
                    case (pick)
                        0:       data[GAIN_W-1:0] = '0;
                        1:       data[GAIN_W-1:0] = GAIN_MAX;
                        2:       data[GAIN_W-1:0] = GAIN_UNITY;
                        3, 4, 5: data[GAIN_W-1:0] = GAIN_W'($urandom_range(0, 32768));
                        default: ;
                    endcase
                end
                write_reg(k[CFG_IDX_W-1:0], data);
            end
        end
        if ($urandom_range(0, 99) < 10)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      CFG_DATA_W'($urandom));
    endtask

    initial begin
        int                         fed;
        int                         n;
        int                         batch;
        int                         pick;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       rst;

        fed   = 0;
        batch = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Default settings: early attack, gain close to zero
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b1);
        send_sample(-16'sd1, 1'b0);
        end_batch();

        // Short cycle through every phase, over-unity peak, wrap at the end
        write_reg(REG_ATTACK, 20'd2);
        write_reg(REG_DECAY, 20'd3);
        write_reg(REG_SUSTAIN, 20'd2);
        write_reg(REG_PEAK, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_SUS_GAIN, '0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sd12345, 1'b0);
        send_sample(16'sh8000, 1'b0);
        end_batch();

        // All lengths zero: every sample wraps; spare indexes must be ignored
        write_reg(REG_ATTACK, '0);
        write_reg(REG_DECAY, '0);
        write_reg(REG_SUSTAIN, '0);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(-16'sd1, 1'b0);
        end_batch();

        // No attack, decay rising from zero to full scale, longest sustain
        write_reg(REG_DECAY, 20'd3);
        write_reg(REG_SUSTAIN, LEN_MAX);
        write_reg(REG_PEAK, '0);
        write_reg(REG_SUS_GAIN, CFG_DATA_W'(GAIN_MAX));
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        end_batch();

        // Longest attack and decay
        write_reg(REG_ATTACK, LEN_MAX);
        write_reg(REG_DECAY, LEN_MAX);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        end_batch();

        while (fed < RANDOM_ITEMS) begin
            random_setup();
            steady_flow = (batch == 3 || batch == 4);
            n = $urandom_range(15, 50);
            for (int i = 0; i < n; i++) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       smp = 16'sh7FFF;
                    1:       smp = 16'sh8000;
                    2:       smp = 16'sh0000;
                    3:       smp = -16'sd1;
                    default: smp = SAMPLE_W'($urandom_range(0, 65535));
                endcase
                rst = (i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 99) < 4;
                send_sample(smp, rst);
                fed++;
            end
            end_batch();
            batch++;
        end
        steady_flow = 1'b0;

        repeat (60) @(posedge aclk);
        if (tracker.outstanding() != 0) begin
            $error("sample_out: %0d results never arrived", tracker.outstanding());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("looping_ads_envelope_gain_unit_tb: done, clean");
        else
            $display("looping_ads_envelope_gain_unit_tb: done, errors");
        $finish;
    end

endmodule
